### hw/rtl/lsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants of the load step detector
// Holds the command, register index and power mode codes and the structs
// that travel between the step decision and the top level.
// ----------------------------------------------------------------------------
package lsd_pkg;

  // Sample and configuration register width.
  localparam int SampleWidth = 16;

  // Command codes of an input item.
  localparam logic CMD_READING = 1'b0;
  localparam logic CMD_LIGHT   = 1'b1;

  // Configuration register indexes.
  localparam int CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] REG_STEP_THRESHOLD = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_POWER_IDLE     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_POWER_LIGHT    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_POWER_LOAD     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_POWER_BOTH     = 3'd4;

  // Reset value of the step threshold in milliamps.
  localparam logic [SampleWidth-1:0] STEP_THRESHOLD_RESET = 16'd500;

  // Power mode codes: bit 0 is the light, bit 1 the load.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_LIGHT = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;
  localparam logic [1:0] MODE_BOTH  = 2'd3;

  // One accepted item as seen by the step decision.
  typedef struct packed {
    logic fire;
    logic is_light;
    logic light_is_on;
  } lsd_event_t;

  // Flag values after the current item.
  typedef struct packed {
    logic load;
    logic light;
  } lsd_flags_t;

endpackage
`default_nettype wire

### hw/rtl/load_step_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// load_step_detector: current step detector combined with a light state
// Turns current readings and light events into one of four power modes.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item, registered in the cycle
// after it is accepted, and a new item can be accepted in every cycle while
// the output does not stall, so throughput is one item per clock. The
// history line keeps running sums of both windows, so each reading costs one
// add and one subtract per window, two constant multiplications and one
// signed compare, all combinational between the state registers and the
// result register. The input stalls only while a result is held by a stalled
// output. The threshold is scaled by both window counts on a write, so writing
// it has no effect on throughput. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module load_step_detector
  import lsd_pkg::*;
#(
  parameter int RECENT_COUNT  = 8,
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Configuration write port
  input  wire logic                     cfg_write,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [SampleWidth-1:0]   cfg_data,
  // Input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     cmd,
  input  wire logic [SampleWidth-1:0]   current_ma,
  input  wire logic                     light_is_on,
  // Output channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic      [1:0]               power_mode,
  output logic      [SampleWidth-1:0]   power_value,
  output logic                          load_on
);

  localparam int RCNT = (RECENT_COUNT < HISTORY_DEPTH) ? RECENT_COUNT : HISTORY_DEPTH;
  localparam int OCNT = (HISTORY_DEPTH - RCNT - 1 > 0) ? HISTORY_DEPTH - RCNT - 1 : 0;
  localparam int ODEN = (OCNT > 0) ? OCNT : 1;
  localparam int RW   = SampleWidth + $clog2(RCNT + 1);
  localparam int OW   = SampleWidth + $clog2(OCNT + 1);
  localparam int LW   = SampleWidth + $clog2(RCNT + 1) + $clog2(ODEN + 1);
  localparam int SCALE = RCNT * ODEN;
  localparam logic [LW-1:0] SCALE_W = LW'(SCALE);

  logic                   accept;
  logic [LW-1:0]          limit;
  logic [SampleWidth-1:0] power_cfg [4];
  logic [RW-1:0]          recent_sum_next;
  logic [OW-1:0]          older_sum_next;
  lsd_event_t             ev;
  lsd_flags_t             flags_next;
  logic [1:0]             mode_next;
  logic [SampleWidth-1:0] value_next;

  // The input moves whenever the result register is empty or being emptied.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Configuration registers; the threshold is kept pre-scaled.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LW'(STEP_THRESHOLD_RESET) * SCALE_W;
      for (int k = 0; k < 4; k++) begin
        power_cfg[k] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_THRESHOLD: limit <= LW'(cfg_data) * SCALE_W;
        REG_POWER_IDLE:     power_cfg[0] <= cfg_data;
        REG_POWER_LIGHT:    power_cfg[1] <= cfg_data;
        REG_POWER_LOAD:     power_cfg[2] <= cfg_data;
        REG_POWER_BOTH:     power_cfg[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  lsd_history #(
    .RECENT_COUNT  (RECENT_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .RCNT          (RCNT),
    .OCNT          (OCNT),
    .RW            (RW),
    .OW            (OW)
  ) u_history (
    .clk             (clk),
    .rst             (rst),
    .shift           (accept && (cmd == CMD_READING)),
    .sample          (current_ma),
    .recent_sum_next (recent_sum_next),
    .older_sum_next  (older_sum_next)
  );

  always_comb begin
    ev.fire        = accept;
    ev.is_light    = (cmd == CMD_LIGHT);
    ev.light_is_on = light_is_on;
  end

  lsd_decide #(
    .RCNT (RCNT),
    .ODEN (ODEN),
    .RW   (RW),
    .OW   (OW),
    .LW   (LW)
  ) u_decide (
    .clk        (clk),
    .rst        (rst),
    .ev         (ev),
    .recent_sum (recent_sum_next),
    .older_sum  (older_sum_next),
    .limit      (limit),
    .flags_next (flags_next)
  );

  // Mode and its configured power value.
  always_comb begin
    mode_next = {flags_next.load, flags_next.light};
    case (mode_next)
      MODE_IDLE:  value_next = power_cfg[0];
      MODE_LIGHT: value_next = power_cfg[1];
      MODE_LOAD:  value_next = power_cfg[2];
      MODE_BOTH:  value_next = power_cfg[3];
      default:    value_next = power_cfg[0];
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      power_mode  <= mode_next;
      power_value <= value_next;
      load_on     <= flags_next.load;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lsd_history.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsd_history: sample history line with running window sums
// Shifts each current reading into the newest end of the line and keeps the
// sums of the recent window and of the older window up to date.
// ----------------------------------------------------------------------------
module lsd_history
  import lsd_pkg::*;
#(
  parameter int RECENT_COUNT  = 8,
  parameter int HISTORY_DEPTH = 64,
  parameter int RCNT = (RECENT_COUNT < HISTORY_DEPTH) ? RECENT_COUNT : HISTORY_DEPTH,
  parameter int OCNT = (HISTORY_DEPTH - RCNT - 1 > 0) ? HISTORY_DEPTH - RCNT - 1 : 0,
  parameter int RW   = SampleWidth + $clog2(RCNT + 1),
  parameter int OW   = SampleWidth + $clog2(OCNT + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   shift,
  input  wire logic [SampleWidth-1:0] sample,
  output logic      [RW-1:0]          recent_sum_next,
  output logic      [OW-1:0]          older_sum_next
);

  logic [SampleWidth-1:0] history [HISTORY_DEPTH];
  logic [RW-1:0]          recent_sum;

  // History shift line, index 0 is the newest sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        history[k] <= '0;
      end
    end else if (shift) begin
      history[0] <= sample;
      for (int k = 1; k < HISTORY_DEPTH; k++) begin
        history[k] <= history[k-1];
      end
    end
  end

  // Recent window sum: the new sample enters, the last recent sample leaves.
  always_comb begin
    recent_sum_next = recent_sum;
    if (shift) begin
      recent_sum_next = recent_sum + RW'(sample) - RW'(history[RCNT-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_sum <= '0;
    end else begin
      recent_sum <= recent_sum_next;
    end
  end

  // Older window sum: fed past the skipped sample, drained at the far end.
  generate
    if (OCNT > 0) begin : g_older
      logic [OW-1:0] older_sum;

      always_comb begin
        older_sum_next = older_sum;
        if (shift) begin
          older_sum_next = older_sum + OW'(history[RCNT])
                         - OW'(history[HISTORY_DEPTH-1]);
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          older_sum <= '0;
        end else begin
          older_sum <= older_sum_next;
        end
      end
    end else begin : g_no_older
      assign older_sum_next = '0;
    end
  endgenerate

endmodule
`default_nettype wire

### hw/rtl/lsd_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsd_decide: step decision with hysteresis
// Compares the scaled window means against the scaled threshold and holds
// the load and light flags.
// ----------------------------------------------------------------------------
module lsd_decide
  import lsd_pkg::*;
#(
  parameter int RCNT = 8,
  parameter int ODEN = 55,
  parameter int RW   = 20,
  parameter int OW   = 22,
  parameter int LW   = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire lsd_event_t ev,
  input  wire logic [RW-1:0] recent_sum,
  input  wire logic [OW-1:0] older_sum,
  input  wire logic [LW-1:0] limit,
  output lsd_flags_t      flags_next
);

  localparam int RPW = RW + $clog2(ODEN + 1);
  localparam int OPW = OW + $clog2(RCNT + 1);
  localparam int MW0 = (RPW > OPW) ? RPW : OPW;
  localparam int MW  = (MW0 > LW) ? MW0 : LW;
  localparam int DW  = MW + 2;
  localparam logic [DW-1:0] ODEN_W = DW'(ODEN);
  localparam logic [DW-1:0] RCNT_W = DW'(RCNT);

  lsd_flags_t flags;

  logic        [DW-1:0] recent_prod;
  logic        [DW-1:0] older_prod;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] lim;

  // Cross-multiplied mean difference; no rounding is involved.
  always_comb begin
    recent_prod = DW'(recent_sum) * ODEN_W;
    older_prod  = DW'(older_sum) * RCNT_W;
    diff        = $signed(recent_prod - older_prod);
    lim         = $signed(DW'(limit));
  end

  // Hysteresis: a rise past the limit sets the flag, a fall past it clears it.
  always_comb begin
    flags_next = flags;
    if (ev.fire) begin
      if (ev.is_light) begin
        flags_next.light = ev.light_is_on;
      end
      if (flags.load) begin
        if (diff < -lim) begin
          flags_next.load = 1'b0;
        end
      end else begin
        if (diff > lim) begin
          flags_next.load = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      flags <= flags_next;
    end
  end

endmodule
`default_nettype wire

### verif/tb_load_step_detector.sv
// ----------------------------------------------------------------------------
// tb_load_step_detector: self-checking testbench of the load step detector
// Walks a short table of directed items and register writes, then runs
// phases of segmented random current traffic under new settings. A local
// predictor of the history line and step decision computes each result not
// fixed by the table, and every result leaving the block is checked in order.
// ----------------------------------------------------------------------------
module tb_load_step_detector;
  import lsd_pkg::*;

  localparam int RECENT_COUNT  = 8;
  localparam int HISTORY_DEPTH = 64;

  // Window counts as the block uses them.
  localparam int RCNT = (RECENT_COUNT < HISTORY_DEPTH) ? RECENT_COUNT : HISTORY_DEPTH;
  localparam int OCNT = (HISTORY_DEPTH - RCNT - 1 > 0) ? HISTORY_DEPTH - RCNT - 1 : 0;
  localparam int ODEN = (OCNT > 0) ? OCNT : 1;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SampleWidth-1:0] value;
    logic                   load;
  } power_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CfgIndexWidth-1:0] reg_idx;
    logic                   cmd;
    logic [SampleWidth-1:0] val;
    logic                   light;
    logic                   fixed;
    power_result_t          exp;
  } stim_row_t;

  localparam int N_ROWS = 28;

  // Directed part: results of the first rows, read off the reset settings, and
  // of one row after the power writes are typed; the rest use the predictor.
  stim_row_t directed_rows [N_ROWS] = '{
    // Recent mean exactly at the threshold: no switch.
    '{ROW_ITEM, 3'd0, CMD_READING, 16'd4000,  1'b0, 1'b1, '{MODE_IDLE,  16'h0000, 1'b0}},
    // Light event re-evaluates the rule but leaves the history alone.
    '{ROW_ITEM, 3'd0, CMD_LIGHT,   16'hFFFF,  1'b1, 1'b1, '{MODE_LIGHT, 16'h0000, 1'b0}},
    // A reading of one milliamp takes the recent mean just past the threshold and switches the load on.
    '{ROW_ITEM, 3'd0, CMD_READING, 16'd1,     1'b1, 1'b1, '{MODE_BOTH,  16'h0000, 1'b1}},
    '{ROW_ITEM, 3'd0, CMD_LIGHT,   16'h0000,  1'b0, 1'b1, '{MODE_LOAD,  16'h0000, 1'b1}},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'hFFFF,  1'b0, 1'b1, '{MODE_LOAD,  16'h0000, 1'b1}},
    // Writes to unknown register indexes must change nothing.
    '{ROW_REG,  3'd5, CMD_READING, 16'h1234,  1'b0, 1'b0, '0},
    '{ROW_REG,  3'd6, CMD_READING, 16'hFFFF,  1'b0, 1'b0, '0},
    '{ROW_REG,  3'd7, CMD_READING, 16'hFFFF,  1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'hFFFF,  1'b1, 1'b1, '{MODE_LOAD,  16'h0000, 1'b1}},
    '{ROW_REG,  REG_STEP_THRESHOLD, CMD_READING, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_POWER_IDLE,     CMD_READING, 16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_POWER_LIGHT,    CMD_READING, 16'h0001, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_POWER_LOAD,     CMD_READING, 16'h8000, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_POWER_BOTH,     CMD_READING, 16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_LIGHT,   16'h0000,  1'b1, 1'b1, '{MODE_BOTH,  16'h7FFF, 1'b1}},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'h0000,  1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'h0000,  1'b1, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_LIGHT,   16'hFFFF,  1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'h8000,  1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'h5555,  1'b1, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'hAAAA,  1'b0, 1'b0, '0},
    '{ROW_REG,  REG_STEP_THRESHOLD, CMD_READING, 16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'h0000,  1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'hFFFF,  1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_LIGHT,   16'h5A5A,  1'b1, 1'b0, '0},
    '{ROW_REG,  REG_STEP_THRESHOLD, CMD_READING, STEP_THRESHOLD_RESET, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'h0000,  1'b1, 1'b0, '0},
    '{ROW_ITEM, 3'd0, CMD_READING, 16'hFFFF,  1'b0, 1'b0, '0}
  };

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [SampleWidth-1:0]   cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     cmd;
  logic [SampleWidth-1:0]   current_ma;
  logic                     light_is_on;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               power_mode;
  logic [SampleWidth-1:0]   power_value;
  logic                     load_on;

  load_step_detector #(
    .RECENT_COUNT (RECENT_COUNT),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .current_ma (current_ma),
    .light_is_on(light_is_on),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .power_mode (power_mode),
    .power_value(power_value),
    .load_on    (load_on)
  );

  // Predictor state: history line, window sums, flags and settings.
  logic [SampleWidth-1:0] hist_line [HISTORY_DEPTH];
  int unsigned            recent_total;
  int unsigned            older_total;
  logic                   load_state;
  logic                   light_state;
  logic [SampleWidth-1:0] thresh_ma;
  logic [SampleWidth-1:0] power_by_mode [4];

  // Results still owed by the block, oldest first.
  power_result_t pending_modes [$];
  power_result_t oldest_mode;
  power_result_t predicted_mode;

  // Typed result of the directed row being offered, if any.
  logic          row_fixed;
  power_result_t row_expect;

  int  mismatch_count;
  int  idle_max;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Resets the predictor to the block's state after reset.
  task automatic clear_predictor();
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      hist_line[k] = '0;
    end
    recent_total = 0;
    older_total  = 0;
    load_state   = 1'b0;
    light_state  = 1'b0;
    thresh_ma    = STEP_THRESHOLD_RESET;
    for (int k = 0; k < 4; k++) begin
      power_by_mode[k] = '0;
    end
  endtask

  // Applies one register write to the predictor's settings.
  function automatic void apply_reg(logic [CfgIndexWidth-1:0] idx, logic [SampleWidth-1:0] data);
    case (idx)
      REG_STEP_THRESHOLD: thresh_ma = data;
      REG_POWER_IDLE:     power_by_mode[MODE_IDLE]  = data;
      REG_POWER_LIGHT:    power_by_mode[MODE_LIGHT] = data;
      REG_POWER_LOAD:     power_by_mode[MODE_LOAD]  = data;
      REG_POWER_BOTH:     power_by_mode[MODE_BOTH]  = data;
      default: ;
    endcase
  endfunction

  // Advances the history or the light state and the load flag by one item and
  // returns the power mode, its power value and the load flag that follow.
  function automatic power_result_t predict_power(logic cmd_in, logic [SampleWidth-1:0] sample,
                                                  logic light_in);
    longint        older_part;
    longint        diff;
    longint        limit;
    logic [1:0]    mode;
    power_result_t res;
    if (cmd_in == CMD_READING) begin
      recent_total = recent_total + sample - hist_line[RCNT-1];
      if (OCNT > 0) begin
        older_total = older_total + hist_line[RCNT] - hist_line[HISTORY_DEPTH-1];
      end
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
        hist_line[k] = hist_line[k-1];
      end
      hist_line[0] = sample;
    end else begin
      light_state = light_in;
    end
    // Means compared exactly, scaled by both window counts.
    older_part = (OCNT > 0) ? longint'(older_total) : 64'sd0;
    diff  = longint'(recent_total) * ODEN - older_part * RCNT;
    limit = longint'(thresh_ma) * RCNT * ODEN;
    if (load_state) begin
      if (diff < -limit) load_state = 1'b0;
    end else begin
      if (diff > limit) load_state = 1'b1;
    end
    if (light_state && load_state) mode = MODE_BOTH;
    else if (load_state) mode = MODE_LOAD;
    else if (light_state) mode = MODE_LIGHT;
    else mode = MODE_IDLE;
    res.mode  = mode;
    res.value = power_by_mode[mode];
    res.load  = load_state;
    return res;
  endfunction

  // Input monitor: every accepted item is run through the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predicted_mode = predict_power(cmd, current_ma, light_is_on);
      if (row_fixed) pending_modes.push_back(row_expect);
      else pending_modes.push_back(predicted_mode);
    end
  end

  // Output monitor: every accepted result is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_modes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result at %0t: mode %0d value %h load %b",
                   $time, power_mode, power_value, load_on);
        end
      end else begin
        oldest_mode = pending_modes.pop_front();
        if (power_mode !== oldest_mode.mode || power_value !== oldest_mode.value ||
            load_on !== oldest_mode.load) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: expected mode %0d value %h load %b, got mode %0d value %h load %b",
                     $time, oldest_mode.mode, oldest_mode.value, oldest_mode.load,
                     power_mode, power_value, load_on);
          end
        end
      end
    end
  end

  // Result side: random stall before each result, and one long hold-off
  // when requested, so the block fills up and stalls its input.
  initial begin
    int wait_n;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        out_stall <= 1'b1;
        for (int k = 1; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
        end
      end
      wait_n = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      if (wait_n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (wait_n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_load_step_detector: done, errors");
    $finish;
  end

  // Offers one item after a random gap and returns once it is accepted.
  task automatic send_item(logic cmd_in, logic [SampleWidth-1:0] sample, logic light_in,
                           logic fixed, power_result_t exp);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= cmd_in;
    current_ma  <= sample;
    light_is_on <= light_in;
    row_fixed   = fixed;
    row_expect  = exp;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering items and waits until every owed result has come.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write, mirrored into the predictor.
  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [SampleWidth-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Random traffic in segments: runs of readings around a level, so the
  // windows fill and real steps occur, mixed with light events and noise.
  task automatic run_traffic(int n_items);
    int left;
    int run_len;
    int level;
    int spread;
    int sample;
    left = n_items;
    while (left > 0) begin
      run_len = $urandom_range(1, 80);
      case ($urandom_range(0, 4))
        0: level = 0;
        1: level = 65535;
        default: level = $urandom_range(0, 65535);
      endcase
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400);
      for (int k = 0; k < run_len && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(CMD_LIGHT, 16'($urandom), 1'($urandom), 1'b0, '0);
        end else begin
          sample = level + $urandom_range(0, spread) - spread / 2;
          if (sample < 0) sample = 0;
          if (sample > 65535) sample = 65535;
          send_item(CMD_READING, 16'(sample), 1'($urandom), 1'b0, '0);
        end
        left--;
      end
    end
  endtask

  // Main sequence: reset, directed table, then random phases.
  initial begin
    logic [SampleWidth-1:0] thr;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    cmd            = CMD_READING;
    current_ma     = '0;
    light_is_on    = 1'b0;
    row_fixed      = 1'b0;
    row_expect     = '0;
    mismatch_count = 0;
    idle_max       = 10;
    hold_req       = 1'b0;
    clear_predictor();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_REG) begin
        drain();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].val);
      end else begin
        send_item(directed_rows[r].cmd, directed_rows[r].val, directed_rows[r].light,
                  directed_rows[r].fixed, directed_rows[r].exp);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      // New settings for this phase, extremes in the first two.
      case (p)
        0: thr = 16'h0000;
        1: thr = 16'hFFFF;
        2: thr = STEP_THRESHOLD_RESET;
        default: thr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
      endcase
      write_reg(REG_STEP_THRESHOLD, thr);
      write_reg(REG_POWER_IDLE,  (p == 1) ? 16'hFFFF : 16'($urandom));
      write_reg(REG_POWER_LIGHT, (p == 1) ? 16'hFFFF : 16'($urandom));
      write_reg(REG_POWER_LOAD,  (p == 0) ? 16'h0000 : 16'($urandom));
      write_reg(REG_POWER_BOTH,  (p == 0) ? 16'h0000 : 16'($urandom));
      idle_max = (p == 3) ? 0 : 10;
      if (p == 2) hold_req = 1'b1;
      run_traffic(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(posedge clk);
    if (pending_modes.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("tb_load_step_detector: done, clean");
    end else begin
      $display("tb_load_step_detector: done, errors");
    end
    $finish;
  end

endmodule
